/* rtl/lcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg
// shared types, constants and helpers of the led current regulator
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int EXTRA_BITS = 2;
  localparam int TIMER_TOP  = 1023;
  localparam int LEVELS     = 4;
  localparam int CHANNELS   = 2;

  localparam int LVL_SLOTS  = 4;
  localparam int LVL_W      = 2;
  localparam int TBL_DEPTH  = CHANNELS * LVL_SLOTS;
  localparam int ADDR_W     = 3;

  localparam int DUTY_W     = 12;
  localparam int CUR_W      = 10;
  localparam int TOL_W      = 8;
  localparam int CMP_W      = 10;
  localparam int ERR_W      = 3;

  localparam int STEP_UNIT     = 1 << EXTRA_BITS;
  localparam int STEP_HALF_M1  = STEP_UNIT / 2 - 1;
  localparam int STEP_FAR_UP   = 3 * STEP_UNIT;
  localparam int STEP_BOOST    = 6 * STEP_UNIT;
  localparam int STEP_FAR_DOWN = 2 * STEP_UNIT;

  localparam int CUR_HIGH       = 20;
  localparam int CUR_LOW        = 10;
  localparam int DUTY_LOW_LIM   = 40 << EXTRA_BITS;
  localparam int DUTY_HIGH_LIM  = (TIMER_TOP * 3 / 4) << EXTRA_BITS;

  localparam logic REG_MAX_CURRENT  = 1'b0;
  localparam logic REG_DUTY_CEILING = 1'b1;

  localparam logic [ERR_W-1:0]     FLAG_ANY   = 3'b001;
  localparam logic [ERR_W-1:0]     FLAG_CH0   = 3'b010;
  localparam logic [TBL_DEPTH-1:0] SLOT_MASK  = 8'h0F;

  typedef enum logic [1:0] {
    MODE_MEASURE = 2'd0,
    MODE_LEVEL   = 2'd1,
    MODE_LOAD    = 2'd2,
    MODE_SAVE    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic               level_ok;
    logic [CUR_W-1:0]   cur;
    logic [DUTY_W-1:0]  duty;
    logic [DUTY_W-1:0]  start_duty;
    logic               enabled;
    logic [CUR_W-1:0]   target;
    logic [TOL_W-1:0]   tolerance;
    logic [DUTY_W-1:0]  saved;
    logic [CUR_W-1:0]   max_current;
    logic [DUTY_W-1:0]  duty_ceiling;
  } step_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               enabled;
    logic               start_we;
    logic [DUTY_W-1:0]  start_duty;
    logic               fault;
  } step_out_t;

  function automatic logic [CMP_W-1:0] compare_of(input logic [DUTY_W-1:0] d);
    logic [DUTY_W-1:0] s;
    s = d >> EXTRA_BITS;
    if (int'(s) > TIMER_TOP) begin
      compare_of = CMP_W'(TIMER_TOP);
    end else begin
      compare_of = s[CMP_W-1:0];
    end
  endfunction

endpackage

/* rtl/lcr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lcr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lcr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_step
// per item duty update: fault checks, level switch and tiered regulation step
// ----------------------------------------------------------------------------
module lcr_step (
  input  lcr_pkg::step_in_t  si,
  output lcr_pkg::step_out_t so
);

  logic signed [12:0] ic, tg, tl;
  logic signed [12:0] lo1, lo2, lo4, hi1, hi2, hi4;
  logic signed [15:0] dsum;
  logic [lcr_pkg::DUTY_W-1:0] reg_duty;
  logic [lcr_pkg::DUTY_W-1:0] sl_duty;
  logic sl_en;
  logic at_start, hard_fault, boost;

  always_comb begin
    ic  = $signed({3'b000, si.cur});
    tg  = $signed({3'b000, si.target});
    tl  = $signed({5'b00000, si.tolerance});
    lo1 = tg - tl;
    lo2 = tg - (tl <<< 1);
    lo4 = tg - (tl <<< 2);
    hi1 = tg + tl;
    hi2 = tg + (tl <<< 1);
    hi4 = tg + (tl <<< 2);

    // level switch
    sl_duty = si.duty;
    sl_en   = si.enabled;
    if (si.target != '0) begin
      if (!si.enabled) begin
        sl_en   = 1'b1;
        sl_duty = si.start_duty;
      end else if (si.saved != '0) begin
        sl_duty = si.saved;
      end
    end else begin
      sl_en   = 1'b0;
      sl_duty = '0;
    end

    // tiered step
    boost = 1'b0;
    dsum  = $signed({4'b0000, si.duty});
    if (ic < lo1) begin
      dsum = dsum + 16'sd1;
      if (ic < lo2) begin
        dsum = dsum + 16'(lcr_pkg::STEP_HALF_M1);
        if (ic < lo4) begin
          dsum = dsum + 16'(lcr_pkg::STEP_FAR_UP);
          if (int'(si.cur) < lcr_pkg::CUR_LOW) begin
            boost = 1'b1;
            dsum  = dsum + 16'(lcr_pkg::STEP_BOOST);
          end
        end
      end
    end
    if (ic > hi1) begin
      dsum = dsum - 16'sd1;
      if (ic > hi2) begin
        dsum = dsum - 16'(lcr_pkg::STEP_HALF_M1);
        if (ic > hi4) begin
          dsum = dsum - 16'(lcr_pkg::STEP_FAR_DOWN);
        end
      end
    end
    if (dsum < 16'sd0) begin
      reg_duty = '0;
    end else if (dsum > $signed({4'b0000, si.duty_ceiling})) begin
      reg_duty = si.duty_ceiling;
    end else begin
      reg_duty = dsum[lcr_pkg::DUTY_W-1:0];
    end

    at_start   = (si.duty == si.start_duty);
    hard_fault = (si.cur > si.max_current)
              || (int'(si.cur) > lcr_pkg::CUR_HIGH && int'(si.duty) < lcr_pkg::DUTY_LOW_LIM)
              || (int'(si.cur) < lcr_pkg::CUR_LOW && int'(si.duty) > lcr_pkg::DUTY_HIGH_LIM)
              || (at_start && int'(si.cur) > lcr_pkg::CUR_HIGH);

    so.duty       = si.duty;
    so.enabled    = si.enabled;
    so.start_we   = 1'b0;
    so.start_duty = si.duty;
    so.fault      = 1'b0;

    case (si.mode)
      lcr_pkg::MODE_MEASURE: begin
        if (hard_fault) begin
          so.fault   = 1'b1;
          so.duty    = '0;
          so.enabled = 1'b0;
        end else if (at_start && sl_duty != si.start_duty) begin
          so.duty    = sl_duty;
          so.enabled = sl_en;
        end else begin
          so.enabled  = at_start ? sl_en : si.enabled;
          so.duty     = reg_duty;
          so.start_we = boost;
        end
      end
      lcr_pkg::MODE_LEVEL: begin
        if (si.level_ok) begin
          so.duty    = sl_duty;
          so.enabled = sl_en;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/led_current_regulator_with_fault.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_current_regulator_with_fault
// two channel led current regulator with short fault detection
// ----------------------------------------------------------------------------
// words enter on the s_ group; s_tuser selects the operation and channel
// (measure, change level, load target entry, save duty). every word gives
// one result word on the m_ group with the channel's duty, pwm compare
// value, enable, fault flag and sticky error flags.
// on input accept the table and saved duty memory reads are issued and
// the word enters the update stage register; when that stage advances
// it updates the channel state and loads the output register.
// throughput is one word per cycle while the output is not stalled; the rate
// is set by the single read-modify-write of the channel duty in the update
// stage, with the saved duty memory forwarded when a save hits the entry being read.
// when m_tready is low the output register holds, the update stage holds
// its word and s_tready drops only once both are full.
// rst is synchronous: all channels off, duties, tables and error flags
// read as zero, max_current 1023 and duty_ceiling 4095. no clearing pass.
// cfg_we writes max_current (index 0) or duty_ceiling (index 1) at once.
// ----------------------------------------------------------------------------
module led_current_regulator_with_fault (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // current_sample, level_select, target_current, tolerance
  input  logic [2:0]  s_tuser,   // mode, channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // duty_value, compare_value, channel_on, fault_now, error_flags
  output logic [0:0]  m_tuser,   // out_channel
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int DW = lcr_pkg::DUTY_W;
  localparam int AW = lcr_pkg::ADDR_W;
  localparam int LW = lcr_pkg::LVL_W;
  localparam int TW = lcr_pkg::CUR_W + lcr_pkg::TOL_W;

  logic [lcr_pkg::CUR_W-1:0] max_current;
  logic [DW-1:0]             duty_ceiling;

  logic [DW-1:0]             duty       [lcr_pkg::CHANNELS];
  logic [DW-1:0]             start_duty [lcr_pkg::CHANNELS];
  logic [LW-1:0]             active_level [lcr_pkg::CHANNELS];
  logic [lcr_pkg::CHANNELS-1:0]  enabled_mask;
  logic [lcr_pkg::ERR_W-1:0]     error_bits;
  logic [lcr_pkg::TBL_DEPTH-1:0] tbl_valid;
  logic [lcr_pkg::TBL_DEPTH-1:0] sv_valid;

  // input side
  lcr_pkg::mode_t            in_mode;
  logic                      in_ch;
  logic [lcr_pkg::CUR_W-1:0] in_cur;
  logic [LW-1:0]             in_lv;
  logic [lcr_pkg::CUR_W-1:0] in_tgt;
  logic [lcr_pkg::TOL_W-1:0] in_tol;
  logic                      in_lv_ok;
  logic [LW-1:0]             rd_lv;
  logic [AW-1:0]             rd_addr;
  logic                      accept;
  logic                      tbl_we;

  // update stage
  logic                      s1_valid;
  lcr_pkg::mode_t            s1_mode;
  logic                      s1_ch;
  logic [lcr_pkg::CUR_W-1:0] s1_cur;
  logic [LW-1:0]             s1_lv;
  logic                      s1_lv_ok;
  logic                      s1_tv;
  logic                      s1_fwd_hit;
  logic [DW-1:0]             s1_fwd_data;
  logic                      s1_adv;
  logic [AW-1:0]             s1_addr;
  logic [TW-1:0]             tbl_q;
  logic [DW-1:0]             sv_q;
  logic [DW-1:0]             saved_val;
  logic                      sv_we;
  lcr_pkg::step_in_t         si;
  lcr_pkg::step_out_t        so;
  logic [lcr_pkg::ERR_W-1:0] error_next;

  always_comb begin
    in_mode  = lcr_pkg::mode_t'(s_tuser[1:0]);
    in_ch    = s_tuser[2];
    in_cur   = s_tdata[9:0];
    in_lv    = s_tdata[11:10];
    in_tgt   = s_tdata[21:12];
    in_tol   = s_tdata[29:22];
    in_lv_ok = int'(in_lv) < lcr_pkg::LEVELS;
    rd_lv    = (in_mode == lcr_pkg::MODE_LEVEL && in_lv_ok) ? in_lv : active_level[in_ch];
    rd_addr  = {in_ch, rd_lv};
  end

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign tbl_we   = accept && in_mode == lcr_pkg::MODE_LOAD && in_lv_ok;
  assign s1_addr  = {s1_ch, s1_lv};
  assign sv_we    = s1_adv && s1_mode == lcr_pkg::MODE_SAVE;

  lcr_ram #(.WIDTH(TW), .DEPTH(lcr_pkg::TBL_DEPTH), .ADDR_W(AW)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr ({in_ch, in_lv}),
    .wdata ({in_tol, in_tgt}),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (tbl_q)
  );

  lcr_ram #(.WIDTH(DW), .DEPTH(lcr_pkg::TBL_DEPTH), .ADDR_W(AW)) u_saved_ram (
    .clk   (clk),
    .we    (sv_we),
    .waddr (s1_addr),
    .wdata (duty[s1_ch]),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (sv_q)
  );

  always_comb begin
    if (!sv_valid[s1_addr]) begin
      saved_val = '0;
    end else if (s1_fwd_hit) begin
      saved_val = s1_fwd_data;
    end else begin
      saved_val = sv_q;
    end
    si.mode         = s1_mode;
    si.level_ok     = s1_lv_ok;
    si.cur          = s1_cur;
    si.duty         = duty[s1_ch];
    si.start_duty   = start_duty[s1_ch];
    si.enabled      = enabled_mask[s1_ch];
    si.target       = s1_tv ? tbl_q[lcr_pkg::CUR_W-1:0] : '0;
    si.tolerance    = s1_tv ? tbl_q[TW-1:lcr_pkg::CUR_W] : '0;
    si.saved        = saved_val;
    si.max_current  = max_current;
    si.duty_ceiling = duty_ceiling;
  end

  lcr_step u_step (
    .si (si),
    .so (so)
  );

  always_comb begin
    error_next = error_bits;
    if (so.fault) begin
      error_next = error_bits | lcr_pkg::FLAG_ANY | (lcr_pkg::FLAG_CH0 << s1_ch);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_current  <= 10'd1023;
      duty_ceiling <= 12'd4095;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcr_pkg::REG_MAX_CURRENT:  max_current  <= cfg_wdata[9:0];
        lcr_pkg::REG_DUTY_CEILING: duty_ceiling <= cfg_wdata;
      endcase
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      tbl_valid       <= '0;
      active_level[0] <= '0;
      active_level[1] <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (tbl_we) begin
        tbl_valid[{in_ch, in_lv}] <= 1'b1;
      end
      if (accept && in_mode == lcr_pkg::MODE_LEVEL && in_lv_ok) begin
        active_level[in_ch] <= in_lv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode     <= in_mode;
      s1_ch       <= in_ch;
      s1_cur      <= in_cur;
      s1_lv       <= rd_lv;
      s1_lv_ok    <= in_lv_ok;
      s1_tv       <= tbl_valid[rd_addr];
      s1_fwd_hit  <= sv_we && (s1_addr == rd_addr);
      s1_fwd_data <= duty[s1_ch];
    end
  end

  // update stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty[0]       <= '0;
      duty[1]       <= '0;
      start_duty[0] <= '0;
      start_duty[1] <= '0;
      enabled_mask  <= '0;
      error_bits    <= '0;
      sv_valid      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s1_adv) begin
        duty[s1_ch]         <= so.duty;
        enabled_mask[s1_ch] <= so.enabled;
        error_bits          <= error_next;
        if (so.start_we) begin
          start_duty[s1_ch] <= so.start_duty;
        end
        if (sv_we) begin
          sv_valid[s1_addr] <= 1'b1;
        end
        if (so.fault) begin
          sv_valid <= sv_valid & ~(lcr_pkg::SLOT_MASK << (s1_ch ? lcr_pkg::LVL_SLOTS : 0));
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tuser <= s1_ch;
      m_tdata <= {5'b00000, error_next, so.fault, so.enabled,
                  lcr_pkg::compare_of(so.duty), so.duty};
    end
  end

  a_fault_turns_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[23] |-> !m_tdata[22] && m_tdata[24] && m_tdata[11:0] == '0)
    else $error("fault result with channel left on or no error flag");

  a_errors_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_bits & $past(error_bits)) == $past(error_bits))
    else $error("error flags cleared without reset");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !s_tready ##1 (s1_valid && $stable(s1_ch) && $stable(s1_mode)))
    else $error("update stage lost its word under stall");

  a_fwd_only_on_save: assert property (@(posedge clk) disable iff (rst)
    accept && s1_adv && s1_mode != lcr_pkg::MODE_SAVE |=> !s1_fwd_hit)
    else $error("saved duty forwarded without a save");

endmodule
